// ===== rtl/time_sync_retry_scheduler_defines.svh =====
// Assertion macros for the time sync retry scheduler.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TIME_SYNC_RETRY_SCHEDULER_DEFINES_SVH
`define TIME_SYNC_RETRY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define TSRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsrs: same-cycle check failed");

// Next-cycle implication, held off during reset
`define TSRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsrs: next-cycle check failed");

`endif

// ===== rtl/tsrs_pkg.sv =====
// Package for the time sync retry scheduler: request and result types,
// configuration register set, register indexes and reset values. No dependencies.
`default_nettype none

package tsrs_pkg;

    localparam int TSRS_TIME_BITS_DEF = 32;

    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_RETRY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTINE_PER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS_PER_Q  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TIMEOUT = 3'd6;

    // reset values
    localparam logic [31:0] RST_STABLE_DELAY  = 32'd60000;
    localparam logic [31:0] RST_BOOT_RETRY    = 32'd30000;
    localparam logic [7:0]  RST_BOOT_MAX      = 8'd10;
    localparam logic [31:0] RST_ROUTINE_PER   = 32'd3000000;
    localparam logic [7:0]  RST_ROUNDS_PER_Q  = 8'd6;
    localparam logic [31:0] RST_MIN_VALID     = 32'd1700000000;
    localparam logic [31:0] RST_QUERY_TIMEOUT = 32'd10000;

    typedef enum logic [1:0] {
        OUTCOME_NONE    = 2'd0,
        OUTCOME_SUCCESS = 2'd1,
        OUTCOME_TIMEOUT = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [31:0] query_timeout_ms;
        logic [31:0] min_valid_time;
        logic [7:0]  rounds_per_query;
        logic [31:0] routine_period_ms;
        logic [7:0]  boot_try_limit;
        logic [31:0] boot_retry_ms;
        logic [31:0] stable_delay_ms;
    } cfg_t;

    // one poll request, last field in the lowest bits
    typedef struct packed {
        logic [31:0] returned_time;
        logic        clock_aligned;
        logic        link_up;
        logic [31:0] now_ms;
    } item_t;

    // one result, last field in the lowest bits
    typedef struct packed {
        logic [7:0]  boot_attempts_used;
        logic        synced_once;
        logic        query_pending;
        logic [31:0] time_to_store;
        outcome_t    query_outcome;
        logic        start_query;
    } result_t;

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);
    localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/tsrs_cfg.sv =====
// Configuration register set of the time sync retry scheduler.
// Depends on tsrs_pkg.
`default_nettype none

module tsrs_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [tsrs_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [31:0]                   wr_data,
    output tsrs_pkg::cfg_t                     cfg
);
    import tsrs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_STABLE_DELAY:  cfg_next.stable_delay_ms   = wr_data;
                CFG_BOOT_RETRY:    cfg_next.boot_retry_ms     = wr_data;
                CFG_BOOT_MAX:      cfg_next.boot_try_limit    = wr_data[7:0];
                CFG_ROUTINE_PER:   cfg_next.routine_period_ms = wr_data;
                CFG_ROUNDS_PER_Q:  cfg_next.rounds_per_query  = wr_data[7:0];
                CFG_MIN_VALID:     cfg_next.min_valid_time    = wr_data;
                CFG_QUERY_TIMEOUT: cfg_next.query_timeout_ms  = wr_data;
                default:           cfg_next = cfg_reg;  // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stable_delay_ms   <= RST_STABLE_DELAY;
            cfg_reg.boot_retry_ms     <= RST_BOOT_RETRY;
            cfg_reg.boot_try_limit    <= RST_BOOT_MAX;
            cfg_reg.routine_period_ms <= RST_ROUTINE_PER;
            cfg_reg.rounds_per_query  <= RST_ROUNDS_PER_Q;
            cfg_reg.min_valid_time    <= RST_MIN_VALID;
            cfg_reg.query_timeout_ms  <= RST_QUERY_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/tsrs_core.sv =====
// Scheduler state and single-pass update logic for one poll request.
// Depends on tsrs_pkg; driven from the top level's input register.
`default_nettype none

module tsrs_core #(
    parameter int TIME_BITS = tsrs_pkg::TSRS_TIME_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  tsrs_pkg::item_t   item,
    input  tsrs_pkg::cfg_t    cfg,
    output tsrs_pkg::result_t result
);
    import tsrs_pkg::*;

    // compare width: time differences against 32-bit settings
    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic                 pending_reg,      pending_next;
    logic                 synced_reg,       synced_next;
    logic [TIME_BITS-1:0] link_since_reg,   link_since_next;
    logic [TIME_BITS-1:0] last_attempt_reg, last_attempt_next;
    logic [TIME_BITS-1:0] last_round_reg,   last_round_next;
    logic [TIME_BITS-1:0] query_start_reg,  query_start_next;
    logic [7:0]           boot_count_reg,   boot_count_next;
    logic [7:0]           round_count_reg,  round_count_next;

    logic [TIME_BITS-1:0] now_t;
    logic                 fresh;
    logic [TIME_BITS-1:0] since_eff;
    logic [TIME_BITS-1:0] attempt_eff;
    logic [7:0]           boot_eff;
    logic [7:0]           round_inc;
    logic                 timed_out;
    logic                 is_stable;
    logic                 boot_due;
    logic                 round_due;
    logic                 start;
    outcome_t             outcome;
    logic [31:0]          store;

    assign now_t       = TIME_BITS'(item.now_ms);
    assign fresh       = (link_since_reg == '0);
    assign since_eff   = fresh ? now_t : link_since_reg;
    assign attempt_eff = fresh ? '0 : last_attempt_reg;
    assign boot_eff    = fresh ? 8'd0 : boot_count_reg;
    assign round_inc   = round_count_reg + 8'd1;

    assign timed_out = CMP_W'(TIME_BITS'(now_t - query_start_reg))
                       >= CMP_W'(cfg.query_timeout_ms);
    assign is_stable = CMP_W'(TIME_BITS'(now_t - since_eff))
                       >= CMP_W'(cfg.stable_delay_ms);
    assign boot_due  = CMP_W'(TIME_BITS'(now_t - attempt_eff))
                       >= CMP_W'(cfg.boot_retry_ms);
    assign round_due = CMP_W'(TIME_BITS'(now_t - last_round_reg))
                       >= CMP_W'(cfg.routine_period_ms);

    always_comb
    begin
        pending_next      = pending_reg;
        synced_next       = synced_reg;
        link_since_next   = link_since_reg;
        last_attempt_next = last_attempt_reg;
        last_round_next   = last_round_reg;
        query_start_next  = query_start_reg;
        boot_count_next   = boot_count_reg;
        round_count_next  = round_count_reg;
        start             = 1'b0;
        outcome           = OUTCOME_NONE;
        store             = '0;

        if (pending_reg)
        begin
            // only answer / timeout checks while a query is out
            if (item.returned_time >= cfg.min_valid_time)
            begin
                pending_next    = 1'b0;
                synced_next     = 1'b1;
                last_round_next = now_t;
                outcome         = OUTCOME_SUCCESS;
                store           = item.returned_time;
            end
            else if (timed_out)
            begin
                pending_next = 1'b0;
                outcome      = OUTCOME_TIMEOUT;
            end
        end
        else if (!item.link_up)
        begin
            link_since_next = '0;
        end
        else
        begin
            link_since_next   = since_eff;
            last_attempt_next = attempt_eff;
            boot_count_next   = boot_eff;
            if (is_stable)
            begin
                if (!synced_reg && (boot_eff < cfg.boot_try_limit))
                begin
                    if (boot_due)
                    begin
                        last_attempt_next = now_t;
                        boot_count_next   = boot_eff + 8'd1;
                        start             = 1'b1;
                    end
                end
                else if (round_due)
                begin
                    last_round_next = now_t;
                    if (!item.clock_aligned)
                    begin
                        start = 1'b1;
                    end
                    else if (round_inc >= cfg.rounds_per_query)
                    begin
                        round_count_next = 8'd0;
                        start            = 1'b1;
                    end
                    else
                    begin
                        round_count_next = round_inc;
                    end
                end
            end
        end

        if (start)
        begin
            pending_next     = 1'b1;
            query_start_next = now_t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg      <= 1'b0;
            synced_reg       <= 1'b0;
            link_since_reg   <= '0;
            last_attempt_reg <= '0;
            last_round_reg   <= '0;
            query_start_reg  <= '0;
            boot_count_reg   <= '0;
            round_count_reg  <= '0;
        end
        else if (advance)
        begin
            pending_reg      <= pending_next;
            synced_reg       <= synced_next;
            link_since_reg   <= link_since_next;
            last_attempt_reg <= last_attempt_next;
            last_round_reg   <= last_round_next;
            query_start_reg  <= query_start_next;
            boot_count_reg   <= boot_count_next;
            round_count_reg  <= round_count_next;
        end
    end

    assign result.start_query        = start;
    assign result.query_outcome      = outcome;
    assign result.time_to_store      = store;
    assign result.query_pending      = pending_next;
    assign result.synced_once        = synced_next;
    assign result.boot_attempts_used = boot_count_next;

endmodule

`default_nettype wire

// ===== rtl/time_sync_retry_scheduler.sv =====
// Top level of the time sync retry scheduler: input and result registers,
// handshakes, configuration set and scheduler core. Depends on tsrs_pkg,
// tsrs_cfg, tsrs_core and time_sync_retry_scheduler_defines.svh.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-------------------------------------
//  s_       | in  | s_tvalid / s_tready   | s_tdata: one poll request
//  m_       | out | m_tvalid / m_tready   | m_tdata: one result per request
//  cfg_     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data: register write
//
// One request in, one result out, one per cycle sustained while m_tready is high.
// A request is held in the input register; the scheduler update runs as one pass
// from there into the result register.
// Reset (rst_n low) clears all scheduler state and restores register defaults.
// A stalled result holds in the result register; the input register still
// takes a request whenever it is empty or moving on in that cycle.
// cfg_ready is always high; writes are expected only while the block is idle.
`default_nettype none
`include "time_sync_retry_scheduler_defines.svh"

module time_sync_retry_scheduler #(
    parameter int TIME_BITS = tsrs_pkg::TSRS_TIME_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // poll requests
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] now_ms, [32] link_up, [33] clock_aligned, [65:34] returned_time,
    // [71:66] zero
    input  wire logic [tsrs_pkg::S_DATA_W-1:0]   s_tdata,
    // results
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] start_query, [2:1] query_outcome, [34:3] time_to_store,
    // [35] query_pending, [36] synced_once, [44:37] boot_attempts_used,
    // [47:45] zero
    output logic [tsrs_pkg::M_DATA_W-1:0]        m_tdata,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data
);
    import tsrs_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    // request moves through the core when the result register can take it
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    tsrs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tsrs_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        if (advance)
            out_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_reg);

    // ---------------------------------------------------------------------
    // checks on internal consistency
    // ---------------------------------------------------------------------
    `TSRS_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)
    `TSRS_ASSERT_NEXT(a_in_held_until_used, in_valid_reg && !advance, in_valid_reg)
    `TSRS_ASSERT_NOW(a_start_leaves_pending, out_valid_reg && out_reg.start_query,
        out_reg.query_pending && (out_reg.query_outcome == OUTCOME_NONE))
    `TSRS_ASSERT_NOW(a_success_marks_synced,
        out_valid_reg && (out_reg.query_outcome == OUTCOME_SUCCESS),
        out_reg.synced_once && !out_reg.query_pending)

endmodule

`default_nettype wire

// ===== verif/tsrs_checker.sv =====
// Checker for the time sync retry scheduler: watches the request, result and
// register channels, predicts every result and compares it field by field.
// Depends on tsrs_pkg only.
`timescale 1ns / 1ps

module tsrs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tsrs_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tsrs_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tsrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             errors,
    output int                             waiting,
    output int                             n_polls,
    output int                             n_launch,
    output int                             n_success,
    output int                             n_timeout
);
    import tsrs_pkg::*;

    // shadow register set and scheduler state
    cfg_t        regs;
    logic        busy;
    logic        synced;
    logic [31:0] link_stamp;
    logic [31:0] attempt_stamp;
    logic [31:0] round_stamp;
    logic [31:0] query_stamp;
    logic [7:0]  boot_tries;
    logic [7:0]  aligned_rounds;

    result_t     due_q[$];
    result_t     want;
    result_t     got;
    int          bad;

    // wrapping difference of two millisecond stamps
    function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] then);
        logic [31:0] d;
        d = now - then;
        return d;
    endfunction

    function automatic result_t advance_scheduler(input item_t p);
        result_t r;
        r = '0;
        r.query_outcome = OUTCOME_NONE;
        if (busy)
        begin
            // pending: only the answer and the timeout matter
            if (p.returned_time >= regs.min_valid_time)
            begin
                busy = 1'b0;
                synced = 1'b1;
                round_stamp = p.now_ms;
                r.query_outcome = OUTCOME_SUCCESS;
                r.time_to_store = p.returned_time;
            end
            else if (since(p.now_ms, query_stamp) >= regs.query_timeout_ms)
            begin
                busy = 1'b0;
                r.query_outcome = OUTCOME_TIMEOUT;
            end
        end
        else if (!p.link_up)
            link_stamp = '0;
        else
        begin
            // a zero stamp means down, so link up at clock zero looks new again
            if (link_stamp == '0)
            begin
                link_stamp = p.now_ms;
                attempt_stamp = '0;
                boot_tries = '0;
            end
            if (since(p.now_ms, link_stamp) >= regs.stable_delay_ms)
            begin
                if (!synced && boot_tries < regs.boot_try_limit)
                begin
                    if (since(p.now_ms, attempt_stamp) >= regs.boot_retry_ms)
                    begin
                        attempt_stamp = p.now_ms;
                        boot_tries = boot_tries + 8'd1;
                        r.start_query = 1'b1;
                    end
                end
                else if (since(p.now_ms, round_stamp) >= regs.routine_period_ms)
                begin
                    round_stamp = p.now_ms;
                    if (!p.clock_aligned)
                        r.start_query = 1'b1;
                    else
                    begin
                        aligned_rounds = aligned_rounds + 8'd1;
                        if (aligned_rounds >= regs.rounds_per_query)
                        begin
                            aligned_rounds = '0;
                            r.start_query = 1'b1;
                        end
                    end
                end
            end
        end
        if (r.start_query)
        begin
            busy = 1'b1;
            query_stamp = p.now_ms;
        end
        r.query_pending = busy;
        r.synced_once = synced;
        r.boot_attempts_used = boot_tries;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.stable_delay_ms   = RST_STABLE_DELAY;
            regs.boot_retry_ms     = RST_BOOT_RETRY;
            regs.boot_try_limit    = RST_BOOT_MAX;
            regs.routine_period_ms = RST_ROUTINE_PER;
            regs.rounds_per_query  = RST_ROUNDS_PER_Q;
            regs.min_valid_time    = RST_MIN_VALID;
            regs.query_timeout_ms  = RST_QUERY_TIMEOUT;
            busy = 1'b0;
            synced = 1'b0;
            link_stamp = '0;
            attempt_stamp = '0;
            round_stamp = '0;
            query_stamp = '0;
            boot_tries = '0;
            aligned_rounds = '0;
            due_q.delete();
            errors <= 0;
            waiting <= 0;
            n_polls <= 0;
            n_launch <= 0;
            n_success <= 0;
            n_timeout <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STABLE_DELAY:  regs.stable_delay_ms   = cfg_data;
                    CFG_BOOT_RETRY:    regs.boot_retry_ms     = cfg_data;
                    CFG_BOOT_MAX:      regs.boot_try_limit    = cfg_data[7:0];
                    CFG_ROUTINE_PER:   regs.routine_period_ms = cfg_data;
                    CFG_ROUNDS_PER_Q:  regs.rounds_per_query  = cfg_data[7:0];
                    CFG_MIN_VALID:     regs.min_valid_time    = cfg_data;
                    CFG_QUERY_TIMEOUT: regs.query_timeout_ms  = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                want = advance_scheduler(s_tdata[ITEM_W-1:0]);
                due_q.push_back(want);
                n_polls <= n_polls + 1;
                n_launch <= n_launch + want.start_query;
                n_success <= n_success + (want.query_outcome == OUTCOME_SUCCESS);
                n_timeout <= n_timeout + (want.query_outcome == OUTCOME_TIMEOUT);
            end

            if (m_tvalid && m_tready)
            begin
                if (due_q.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = due_q.pop_front();
                    got = m_tdata[RESULT_W-1:0];
                    bad = 0;
                    if (got.start_query !== want.start_query)
                    begin
                        $error("start_query: expected %0d, got %0d",
                               want.start_query, got.start_query);
                        bad++;
                    end
                    if (got.query_outcome !== want.query_outcome)
                    begin
                        $error("query_outcome: expected %0d, got %0d",
                               want.query_outcome, got.query_outcome);
                        bad++;
                    end
                    if (got.time_to_store !== want.time_to_store)
                    begin
                        $error("time_to_store: expected %0d, got %0d",
                               want.time_to_store, got.time_to_store);
                        bad++;
                    end
                    if (got.query_pending !== want.query_pending)
                    begin
                        $error("query_pending: expected %0d, got %0d",
                               want.query_pending, got.query_pending);
                        bad++;
                    end
                    if (got.synced_once !== want.synced_once)
                    begin
                        $error("synced_once: expected %0d, got %0d",
                               want.synced_once, got.synced_once);
                        bad++;
                    end
                    if (got.boot_attempts_used !== want.boot_attempts_used)
                    begin
                        $error("boot_attempts_used: expected %0d, got %0d",
                               want.boot_attempts_used, got.boot_attempts_used);
                        bad++;
                    end
                    errors <= errors + bad;
                end
            end

            waiting <= due_q.size();
        end
    end

endmodule

// ===== verif/tb_time_sync_retry_scheduler.sv =====
// Testbench top for the time sync retry scheduler: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on tsrs_pkg, the block itself and tsrs_checker.
`timescale 1ns / 1ps

module tb_time_sync_retry_scheduler;
    import tsrs_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    // covers the input and result registers of the block, plus a little margin
    localparam int SETTLE_CYCLES = 4;
    // generous: well above the slowest legal run
    localparam int CYCLE_LIMIT   = 300000;
    // one long receiver stall, started once enough requests have gone in
    localparam int HOLD_AT       = 120;
    localparam int HOLD_CYCLES   = 200;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int errors;
    int waiting;
    int n_polls;
    int n_launch;
    int n_success;
    int n_timeout;

    // stimulus-side bookkeeping
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          polls_sent  = 0;
    int          settings    = 0;
    int          cycles      = 0;
    int          hold_left   = 0;
    logic        hold_done   = 1'b0;
    logic [31:0] clock_ms    = '0;
    cfg_t        cur;

    always #(CLK_PERIOD / 2) clk = ~clk;

    time_sync_retry_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tsrs_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .waiting   (waiting),
        .n_polls   (n_polls),
        .n_launch  (n_launch),
        .n_success (n_success),
        .n_timeout (n_timeout)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver. Random back-pressure at the current rate, except for one long
    // stall counted here: the sender keeps offering meanwhile, so the input
    // and result registers fill and s_tready has to drop.
    always @(posedge clk)
    begin
        if (!hold_done && polls_sent >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic cfg_t make_setting(input logic [31:0] stable, input logic [31:0] retry,
                                          input logic [7:0] boot_max, input logic [31:0] routine,
                                          input logic [7:0] rounds, input logic [31:0] min_valid,
                                          input logic [31:0] timeout);
        cfg_t c;
        c.stable_delay_ms   = stable;
        c.boot_retry_ms     = retry;
        c.boot_try_limit    = boot_max;
        c.routine_period_ms = routine;
        c.rounds_per_query  = rounds;
        c.min_valid_time    = min_valid;
        c.query_timeout_ms  = timeout;
        return c;
    endfunction

    // One register write; cfg_valid is left high so back-to-back writes
    // never lower and raise it in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_setting(input cfg_t c);
        write_reg(CFG_STABLE_DELAY,  c.stable_delay_ms);
        write_reg(CFG_BOOT_RETRY,    c.boot_retry_ms);
        write_reg(CFG_BOOT_MAX,      {24'd0, c.boot_try_limit});
        write_reg(CFG_ROUTINE_PER,   c.routine_period_ms);
        write_reg(CFG_ROUNDS_PER_Q,  {24'd0, c.rounds_per_query});
        write_reg(CFG_MIN_VALID,     c.min_valid_time);
        write_reg(CFG_QUERY_TIMEOUT, c.query_timeout_ms);
        cfg_valid <= 1'b0;
        cur = c;
        settings++;
    endtask

    // Offer one poll request, after a random idle gap, and wait for it to go in.
    task automatic send_poll(input item_t p);
        logic [S_DATA_W-1:0] word;
        word = '0;
        word[ITEM_W-1:0] = p;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        polls_sent <= polls_sent + 1;
    endtask

    task automatic poll(input logic [31:0] now, input logic link, input logic aligned,
                        input logic [31:0] seen);
        item_t p;
        p.now_ms = now;
        p.link_up = link;
        p.clock_aligned = aligned;
        p.returned_time = seen;
        send_poll(p);
    endtask

    // Stop offering and wait for every predicted result to come back. The
    // checker's count is registered, hence the first edge before looking.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A run of random polls under one register setting. The clock mostly
    // creeps forward with the link held up, so the link-stable wait, boot
    // retries and routine rounds are all reached; now and then it jumps,
    // wraps, sits at zero or the link drops. Halfway, the sender pauses
    // until everything outstanding has come back.
    task automatic run_phase(input cfg_t c, input int n, input int step_max);
        item_t p;
        int    roll;
        drain_results();
        load_setting(c);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 3)
                clock_ms = $urandom;
            else if (roll < 4)
                clock_ms = '0;
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);
            p.now_ms = clock_ms;
            p.link_up = ($urandom_range(0, 99) >= 7);
            p.clock_aligned = 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 99);
            if (roll < 8)
                p.returned_time = $urandom;
            else if (roll < 16)
                p.returned_time = (cur.min_valid_time > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF :
                                  cur.min_valid_time + $urandom_range(0, 15);
            else if (roll < 26)
                p.returned_time = cur.min_valid_time - 32'd1;
            else if (cur.min_valid_time == '0)
                p.returned_time = '0;
            else
                p.returned_time = $urandom_range(0, cur.min_valid_time - 32'd1);
            send_poll(p);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver heavily.
        tx_idle_pct = 34;
        rx_idle_pct <= 86;

        // Directed: small timings so every path shows within a few polls.
        load_setting(make_setting(32'd10, 32'd5, 8'd2, 32'd20, 8'd2, 32'd1000, 32'd8));
        poll(32'd0, 1'b1, 1'b0, 32'd0);            // link up at clock zero: stamp stays 0
        poll(32'd3, 1'b1, 1'b0, 32'd0);            // link taken as newly up
        poll(32'd13, 1'b1, 1'b0, 32'd0);           // stable: first boot attempt
        poll(32'd14, 1'b1, 1'b0, 32'd999);         // one below the valid threshold
        poll(32'd21, 1'b0, 1'b1, 32'd0);           // timeout; link ignored while pending
        poll(32'd22, 1'b1, 1'b0, 32'd0);           // second boot attempt
        poll(32'd23, 1'b1, 1'b0, 32'd1000);        // answer exactly at threshold
        poll(32'd30, 1'b1, 1'b1, 32'd0);           // routine round not yet due
        poll(32'd43, 1'b1, 1'b1, 32'd0);           // aligned round, no query
        poll(32'd63, 1'b1, 1'b1, 32'd0);           // aligned round, query
        poll(32'd64, 1'b1, 1'b1, 32'hFFFF_FFFF);   // largest answer
        poll(32'd84, 1'b1, 1'b0, 32'd0);           // unaligned round, query
        poll(32'd85, 1'b0, 1'b0, 32'd0);
        poll(32'd92, 1'b0, 1'b0, 32'd0);           // timeout at the limit
        poll(32'd93, 1'b0, 1'b0, 32'd0);           // link down clears the stamp
        poll(32'hFFFF_FFF0, 1'b1, 1'b0, 32'd0);
        poll(32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0);    // largest clock value
        poll(32'd5, 1'b1, 1'b0, 32'd0);            // clock wrapped
        poll(32'd7, 1'b1, 1'b0, 32'h5555_5555);    // answer after the clock wrap
        poll(32'd10, 1'b1, 1'b1, 32'd0);
        poll(32'd20, 1'b1, 1'b0, 32'h8000_0000);   // answer ignored when idle
        poll(32'd21, 1'b1, 1'b0, 32'hAAAA_AAAA);

        run_phase(make_setting(32'd20, 32'd10, 8'd4, 32'd40, 8'd3, 32'd5000, 32'd15), 220, 6);
        // all zero: rounds_per_query of zero means every aligned round queries
        run_phase(make_setting(32'd0, 32'd0, 8'd0, 32'd0, 8'd0, 32'd0, 32'd0), 80, 3);

        // Then the other way round.
        tx_idle_pct = 86;
        rx_idle_pct <= 34;
        run_phase(make_setting(32'd0, 32'd3, 8'd255, 32'd5, 8'd1, 32'hFFFF_FFFF, 32'd0), 150, 4);
        run_phase(make_setting(RST_STABLE_DELAY, RST_BOOT_RETRY, RST_BOOT_MAX, RST_ROUTINE_PER,
                               RST_ROUNDS_PER_Q, RST_MIN_VALID, RST_QUERY_TIMEOUT), 200, 40000);

        // No idling at all.
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_phase(make_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 8'd255,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF), 60, 1000);
        run_phase(make_setting(32'd50, 32'd7, 8'd6, 32'd25, 8'd4, 32'h8000_0000, 32'd30), 340, 8);

        drain_results();

        $display("Covered %0d poll requests over %0d register settings: %0d queries launched,",
                 n_polls, settings, n_launch);
        $display("%0d answered, %0d timed out, with random and long receiver stalls.",
                 n_success, n_timeout);
        if (errors == 0 && waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
